// ----- sv/mrc_pkg.sv -----
`timescale 1ns / 1ps
package mrc_pkg;

  localparam int SLOTS  = 4;          // residue positions on the ports
  localparam int MW     = 16;         // modulus, residue and digit width
  localparam int MUW    = 2 * MW;     // Barrett reciprocal width
  localparam int SW     = MW + 2;     // signed Bezout coefficient width
  localparam int IDXW   = 2;          // lane index width
  localparam int CFG_IW = 3;          // configuration index width
  localparam int CFG_DW = 16;         // configuration data width
  localparam int DIV_NW = MUW + 1;    // divider dividend width
  localparam int VALW   = 64;         // binary value width

  localparam logic [SLOTS-1:0][MW-1:0] MOD_RESET = {16'd65479, 16'd65497, 16'd65519, 16'd65521};

  // Residue word as it moves through the digit rounds.
  typedef struct packed {
    logic                      err;
    logic [SLOTS-1:0][MW-1:0]  x;
  } mrc_word_t;

  // Per-base constants worked out after every modulus change.
  typedef struct packed {
    logic                                bad;
    logic [SLOTS-1:0][SLOTS-1:0][MW-1:0] inv;
    logic [SLOTS-1:0][MUW-1:0]           mu;
  } mrc_base_t;

  typedef enum logic [2:0] {
    SEQ_CHECK,
    SEQ_MU,
    SEQ_MU_WAIT,
    SEQ_PMOD,
    SEQ_PMOD_WAIT,
    SEQ_EUC,
    SEQ_EUC_WAIT,
    SEQ_DONE
  } mrc_seq_e;

endpackage

// ----- sv/rns_mixed_radix_conversion_unit.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                         Beat taken when
// cfg       cfg_we, cfg_index, cfg_wdata                  cfg_we high
// in        in_valid/in_ready, in_residue_0..3            in_valid && in_ready
// out       out_valid/out_ready, out_value, out_digit_0..3,
//           out_error                                     out_valid && out_ready
//
// One beat per cycle sustained while out_ready stays high and setup is done; the pipeline is
// one check stage, a seven-stage digit round per mixed-radix
// step, three Horner multiply stages.
// After reset and after every modulus write a setup sequencer works out the
// Barrett reciprocals and pairwise inverses on one 33-step serial divider; in_ready
// stays low while it runs.
// Every stage holds its valid bit; a stall on out_ready backs up stage by stage,
// bubbles collapse, and nothing is dropped or repeated.
module rns_mixed_radix_conversion_unit import mrc_pkg::*; #(
  parameter int NUM_MODULI    = 4,
  parameter int MODULUS_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MW-1:0]     in_residue_0,
  input  logic [MW-1:0]     in_residue_1,
  input  logic [MW-1:0]     in_residue_2,
  input  logic [MW-1:0]     in_residue_3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VALW-1:0]   out_value,
  output logic [MW-1:0]     out_digit_0,
  output logic [MW-1:0]     out_digit_1,
  output logic [MW-1:0]     out_digit_2,
  output logic [MW-1:0]     out_digit_3,
  output logic              out_error
);

  localparam logic [MW-1:0] WMASK = MW'((32'd1 << MODULUS_WIDTH) - 32'd1);

  logic [SLOTS-1:0][MW-1:0] modulus_r;
  logic [SLOTS-1:0][MW-1:0] p_used;
  logic [SLOTS-1:0][MW-1:0] res;
  logic                     cfg_hit;
  logic                     base_ready;
  mrc_base_t                base;
  logic                     v0_r;
  mrc_word_t                w0_r;
  mrc_word_t                w0_nxt;
  logic                     front_rdy;
  logic                     ch_valid [NUM_MODULI];
  logic                     ch_ready [NUM_MODULI];
  mrc_word_t                ch_word  [NUM_MODULI];
  logic [SLOTS-1:0][MW-1:0] digit;

  // Modulus registers; writes beyond the list are dropped.
  assign cfg_hit = cfg_we && (cfg_index < CFG_IW'(SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_hit) begin
      modulus_r[cfg_index[IDXW-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) p_used[i] = modulus_r[i] & WMASK;
  end

  // Setup: reciprocals, inverses, base validity.
  mrc_base #(.NUM_MODULI(NUM_MODULI)) u_base (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_hit),
    .p     (p_used),
    .ready (base_ready),
    .base  (base)
  );

  // Front stage: flag a bad base or a residue not below its modulus.
  assign res = {in_residue_3, in_residue_2, in_residue_1, in_residue_0};

  always_comb begin
    w0_nxt.x   = res;
    w0_nxt.err = base.bad;
    for (int i = 0; i < NUM_MODULI; i++) begin
      if (res[i] >= p_used[i]) w0_nxt.err = 1'b1;
    end
  end

  assign front_rdy = !v0_r || ch_ready[0];
  assign in_ready  = front_rdy && base_ready && !cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (front_rdy) begin
      v0_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (front_rdy) w0_r <= w0_nxt;
  end

  assign ch_valid[0] = v0_r;
  assign ch_word[0]  = w0_r;

  // One round per digit but the last: strip digit j from every later lane.
  for (genvar j = 0; j < NUM_MODULI - 1; j++) begin : g_round
    mrc_round #(.J(j)) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .p         (p_used),
      .base      (base),
      .in_valid  (ch_valid[j]),
      .in_ready  (ch_ready[j]),
      .in_word   (ch_word[j]),
      .out_valid (ch_valid[j+1]),
      .out_ready (ch_ready[j+1]),
      .out_word  (ch_word[j+1])
    );
  end

  // Weighted sum of digits, Horner form.
  mrc_horner #(.NUM_MODULI(NUM_MODULI)) u_horner (
    .clk       (clk),
    .rst_n     (rst_n),
    .p         (p_used),
    .in_valid  (ch_valid[NUM_MODULI-1]),
    .in_ready  (ch_ready[NUM_MODULI-1]),
    .in_word   (ch_word[NUM_MODULI-1]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_digit (digit),
    .out_err   (out_error)
  );

  assign out_digit_0 = digit[0];
  assign out_digit_1 = digit[1];
  assign out_digit_2 = digit[2];
  assign out_digit_3 = digit[3];

  // An error beat carries an all-zero payload.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_value == '0 && out_digit_0 == '0 &&
      out_digit_1 == '0 && out_digit_2 == '0 && out_digit_3 == '0)
    else $error("error beat with nonzero payload");

  // A modulus write restarts setup and closes the input.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !in_ready)
    else $error("input open right after modulus write");

  // No beat enters while setup is running.
  a_setup_gate: assert property (@(posedge clk) disable iff (!rst_n)
    !base_ready |-> !(in_valid && in_ready))
    else $error("beat accepted during setup");

endmodule

// ----- sv/mrc_div.sv -----
`timescale 1ns / 1ps
module mrc_div import mrc_pkg::*; #(
  parameter int NW = 33,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CW'(NW);
        run_r <= 1'b1;
      end else if (run_r) begin
        // one restoring step per cycle
        q_r   <= {q_r[NW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ----- sv/mrc_base.sv -----
`timescale 1ns / 1ps
module mrc_base import mrc_pkg::*; #(
  parameter int NUM_MODULI = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [SLOTS-1:0][MW-1:0] p,
  output logic                     ready,
  output mrc_base_t                base
);

  mrc_seq_e                            state_r, state_nxt;
  logic [IDXW-1:0]                     i_r, i_nxt, j_r, j_nxt;
  logic [MW-1:0]                       r0_r, r0_nxt, r1_r, r1_nxt;
  logic signed [SW-1:0]                s0_r, s0_nxt, s1_r, s1_nxt;
  logic                                bad_r, bad_nxt;
  logic [SLOTS-1:0][SLOTS-1:0][MW-1:0] inv_r, inv_nxt;
  logic [SLOTS-1:0][MUW-1:0]           mu_r, mu_nxt;
  logic                                div_go;
  logic [DIV_NW-1:0]                   div_num;
  logic [MW-1:0]                       div_den;
  logic                                div_done;
  logic [DIV_NW-1:0]                   div_quot;
  logic [MW-1:0]                       div_rem;

  mrc_div #(.NW(DIV_NW), .DW(MW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_CHECK;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    inv_r <= inv_nxt;
    mu_r  <= mu_nxt;
  end

  always_comb begin
    logic signed [SW+MW:0] qs;
    logic signed [SW-1:0]  sp;
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    bad_nxt   = bad_r;
    inv_nxt   = inv_r;
    mu_nxt    = mu_r;
    div_go    = 1'b0;
    div_num   = '0;
    div_den   = p[i_r];
    qs        = $signed({1'b0, div_quot[MW-1:0]}) * s1_r;
    sp        = s0_r + $signed({2'b00, p[j_r]});
    case (state_r)
      SEQ_CHECK: begin
        bad_nxt = 1'b0;
        for (int k = 0; k < NUM_MODULI; k++) begin
          if (p[k] < MW'(2)) bad_nxt = 1'b1;
        end
        i_nxt     = '0;
        state_nxt = bad_nxt ? SEQ_DONE : SEQ_MU;
      end
      SEQ_MU: begin
        // reciprocal floor(2^32 / p) for the Barrett reductions
        div_go    = 1'b1;
        div_num   = DIV_NW'(1) << MUW;
        div_den   = p[i_r];
        state_nxt = SEQ_MU_WAIT;
      end
      SEQ_MU_WAIT: begin
        if (div_done) begin
          mu_nxt[i_r] = div_quot[MUW-1:0];
          if (i_r == IDXW'(NUM_MODULI - 1)) begin
            i_nxt     = '0;
            j_nxt     = IDXW'(1);
            state_nxt = SEQ_PMOD;
          end else begin
            i_nxt     = i_r + IDXW'(1);
            state_nxt = SEQ_MU;
          end
        end
      end
      SEQ_PMOD: begin
        div_go    = 1'b1;
        div_num   = DIV_NW'(p[i_r]);
        div_den   = p[j_r];
        state_nxt = SEQ_PMOD_WAIT;
      end
      SEQ_PMOD_WAIT: begin
        if (div_done) begin
          r0_nxt    = p[j_r];
          r1_nxt    = div_rem;
          s0_nxt    = '0;
          s1_nxt    = SW'(1);
          state_nxt = SEQ_EUC;
        end
      end
      SEQ_EUC: begin
        if (r1_r == '0) begin
          if (r0_r != MW'(1)) begin
            bad_nxt   = 1'b1;
            state_nxt = SEQ_DONE;
          end else begin
            inv_nxt[i_r][j_r] = (s0_r < 0) ? sp[MW-1:0] : s0_r[MW-1:0];
            if (j_r == IDXW'(NUM_MODULI - 1)) begin
              if (i_r == IDXW'(NUM_MODULI - 2)) begin
                state_nxt = SEQ_DONE;
              end else begin
                i_nxt     = i_r + IDXW'(1);
                j_nxt     = i_r + IDXW'(2);
                state_nxt = SEQ_PMOD;
              end
            end else begin
              j_nxt     = j_r + IDXW'(1);
              state_nxt = SEQ_PMOD;
            end
          end
        end else begin
          div_go    = 1'b1;
          div_num   = DIV_NW'(r0_r);
          div_den   = r1_r;
          state_nxt = SEQ_EUC_WAIT;
        end
      end
      SEQ_EUC_WAIT: begin
        if (div_done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          s0_nxt    = s1_r;
          s1_nxt    = s0_r - SW'(qs);
          state_nxt = SEQ_EUC;
        end
      end
      SEQ_DONE: begin
        state_nxt = SEQ_DONE;
      end
      default: begin
        state_nxt = SEQ_CHECK;
      end
    endcase
    // restart on any modulus change
    if (start) state_nxt = SEQ_CHECK;
  end

  assign ready    = (state_r == SEQ_DONE);
  assign base.bad = bad_r;
  assign base.inv = inv_r;
  assign base.mu  = mu_r;

endmodule

// ----- sv/mrc_round.sv -----
`timescale 1ns / 1ps
module mrc_round import mrc_pkg::*; #(
  parameter int J = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SLOTS-1:0][MW-1:0] p,
  input  mrc_base_t                base,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mrc_word_t                in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output mrc_word_t                out_word
);

  localparam int NS = 7;

  logic [NS-1:0]             v_r;
  logic [NS-1:0]             rdy;
  mrc_word_t                 w_r [NS];
  logic [SLOTS-1:0][MW-1:0]  qd_nxt, qd_r;
  logic [SLOTS-1:0][MW:0]    rd_nxt, rd_r;
  logic [SLOTS-1:0][MW-1:0]  df_nxt, df_r;
  logic [SLOTS-1:0][MUW-1:0] y_nxt, y_r, y5_r;
  logic [SLOTS-1:0][MUW-1:0] q_nxt, q_r;
  logic [SLOTS-1:0][MW:0]    r_nxt, r_r;
  mrc_word_t                 fin_nxt;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_comb begin
    logic [MW+MUW-1:0] pd;
    logic [2*MUW-1:0]  pm;
    logic [MW:0]       t2;
    logic [MW-1:0]     dm;
    logic [MW-1:0]     xx;
    fin_nxt = w_r[NS-2];
    for (int i = 0; i < SLOTS; i++) begin
      qd_nxt[i] = '0;
      rd_nxt[i] = '0;
      df_nxt[i] = '0;
      y_nxt[i]  = '0;
      q_nxt[i]  = '0;
      r_nxt[i]  = '0;
      if (i > J) begin
        // d mod p: Barrett quotient, remainder, correct
        pd        = (MW+MUW)'(in_word.x[J]) * (MW+MUW)'(base.mu[i]);
        qd_nxt[i] = pd[MW+MUW-1:MUW];
        t2        = (MW+1)'(qd_r[i]) * (MW+1)'(p[i]);
        rd_nxt[i] = {1'b0, w_r[0].x[J]} - t2;
        dm        = (rd_r[i] >= {1'b0, p[i]}) ? MW'(rd_r[i] - {1'b0, p[i]}) : rd_r[i][MW-1:0];
        xx        = w_r[1].x[i];
        df_nxt[i] = (xx >= dm) ? (xx - dm) : MW'({1'b0, xx} + {1'b0, p[i]} - {1'b0, dm});
        // times the inverse, then reduce the product
        y_nxt[i]  = MUW'(df_r[i]) * MUW'(base.inv[J][i]);
        pm        = (2*MUW)'(y_r[i]) * (2*MUW)'(base.mu[i]);
        q_nxt[i]  = pm[2*MUW-1:MUW];
        r_nxt[i]  = y5_r[i][MW:0] - (MW+1)'(q_r[i][MW:0] * {1'b0, p[i]});
        fin_nxt.x[i] = (r_r[i] >= {1'b0, p[i]}) ? MW'(r_r[i] - {1'b0, p[i]}) : r_r[i][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      w_r[0] <= in_word;
      qd_r   <= qd_nxt;
    end
    if (rdy[1]) begin
      w_r[1] <= w_r[0];
      rd_r   <= rd_nxt;
    end
    if (rdy[2]) begin
      w_r[2] <= w_r[1];
      df_r   <= df_nxt;
    end
    if (rdy[3]) begin
      w_r[3] <= w_r[2];
      y_r    <= y_nxt;
    end
    if (rdy[4]) begin
      w_r[4] <= w_r[3];
      y5_r   <= y_r;
      q_r    <= q_nxt;
    end
    if (rdy[5]) begin
      w_r[5] <= w_r[4];
      r_r    <= r_nxt;
    end
    if (rdy[6]) begin
      w_r[6] <= fin_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_word  = w_r[NS-1];

endmodule

// ----- sv/mrc_horner.sv -----
`timescale 1ns / 1ps
module mrc_horner import mrc_pkg::*; #(
  parameter int NUM_MODULI = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SLOTS-1:0][MW-1:0] p,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mrc_word_t                in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VALW-1:0]          out_value,
  output logic [SLOTS-1:0][MW-1:0] out_digit,
  output logic                     out_err
);

  localparam int AW1 = 2 * MW;
  localparam int AW2 = 3 * MW;

  logic [2:0]               v_r;
  logic [2:0]               rdy;
  logic [SLOTS-1:0][MW-1:0] dm_nxt;
  logic [SLOTS-1:0][MW-1:0] d_r [3];
  logic                     e_r [3];
  logic [AW1-1:0]           a1_nxt, a1_r;
  logic [AW2-1:0]           a2_r;
  logic [VALW-1:0]          val_r;

  assign rdy[2] = !v_r[2] || out_ready;
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      dm_nxt[i] = (!in_word.err && i < NUM_MODULI) ? in_word.x[i] : '0;
    end
    a1_nxt = AW1'(dm_nxt[3]) * AW1'(p[2]) + AW1'(dm_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d_r[0] <= dm_nxt;
      e_r[0] <= in_word.err;
      a1_r   <= a1_nxt;
    end
    if (rdy[1]) begin
      d_r[1] <= d_r[0];
      e_r[1] <= e_r[0];
      a2_r   <= AW2'(a1_r) * AW2'(p[1]) + AW2'(d_r[0][1]);
    end
    if (rdy[2]) begin
      d_r[2] <= d_r[1];
      e_r[2] <= e_r[1];
      val_r  <= VALW'(a2_r) * VALW'(p[0]) + VALW'(d_r[1][0]);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[2];
  assign out_value = val_r;
  assign out_digit = d_r[2];
  assign out_err   = e_r[2];

endmodule

// ----- verif/rns_mixed_radix_conversion_unit_checker.sv -----
`timescale 1ns / 1ps
module rns_mixed_radix_conversion_unit_checker import mrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [MW-1:0]     in_residue_0,
  input  logic [MW-1:0]     in_residue_1,
  input  logic [MW-1:0]     in_residue_2,
  input  logic [MW-1:0]     in_residue_3,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [VALW-1:0]   out_value,
  input  logic [MW-1:0]     out_digit_0,
  input  logic [MW-1:0]     out_digit_1,
  input  logic [MW-1:0]     out_digit_2,
  input  logic [MW-1:0]     out_digit_3,
  input  logic              out_error,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [VALW-1:0]          value;
    logic [SLOTS-1:0][MW-1:0] digit;
    logic                     error;
  } conversion_t;

  logic [SLOTS-1:0][MW-1:0] base;
  conversion_t              awaited[$];

  // Extended Euclid; returns gcd(x, p) and x^-1 mod p when it is one.
  function automatic longint modular_inverse(input longint x, input longint p,
                                             output longint inv);
    longint r0, r1, s0, s1, q, rt, st;
    r0 = p; r1 = x; s0 = 0; s1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      st = s0 - q * s1;
      r0 = r1; r1 = rt;
      s0 = s1; s1 = st;
    end
    if (s0 < 0) s0 += p;
    inv = s0 % p;
    return r0;
  endfunction

  function automatic conversion_t convert(input logic [SLOTS-1:0][MW-1:0] res);
    conversion_t  c;
    longint       inv[SLOTS][SLOTS];
    longint       x, g;
    logic [63:0]  weight;
    bit           bad;
    c = '0;
    bad = 0;
    for (int i = 0; i < SLOTS; i++)
      if (base[i] < 2 || res[i] >= base[i]) bad = 1;
    if (!bad)
      for (int i = 0; i < SLOTS; i++)
        for (int j = i + 1; j < SLOTS; j++) begin
          g = modular_inverse(64'(base[i] % base[j]), 64'(base[j]), inv[i][j]);
          if (g != 1) bad = 1;
        end
    if (bad) begin
      c.error = 1'b1;
      return c;
    end
    weight = 64'd1;
    for (int i = 0; i < SLOTS; i++) begin
      x = 64'(res[i]);
      for (int j = 0; j < i; j++) begin
        x = (x + base[i] - (c.digit[j] % base[i])) % base[i];
        x = (x * inv[j][i]) % base[i];
      end
      c.digit[i] = x[MW-1:0];
      c.value += weight * 64'(x);
      weight *= 64'(base[i]);
    end
    return c;
  endfunction

  task automatic compare(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  assign pending = awaited.size();

  always @(posedge clk) begin
    conversion_t want;
    if (!rst_n) begin
      base       <= MOD_RESET;
      mismatches = 0;
      awaited.delete();
    end else begin
      // moduli only change while idle, so ordering against beats is moot
      if (cfg_we && cfg_index < CFG_IW'(SLOTS)) base[cfg_index[IDXW-1:0]] <= cfg_wdata;
      if (in_valid && in_ready)
        awaited.push_back(convert({in_residue_3, in_residue_2, in_residue_1, in_residue_0}));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t unexpected beat value %h error %b", $time, out_value, out_error);
        end else begin
          want = awaited.pop_front();
          compare("value", want.value, out_value);
          compare("digit_0", 64'(want.digit[0]), 64'(out_digit_0));
          compare("digit_1", 64'(want.digit[1]), 64'(out_digit_1));
          compare("digit_2", 64'(want.digit[2]), 64'(out_digit_2));
          compare("digit_3", 64'(want.digit[3]), 64'(out_digit_3));
          compare("error", 64'(want.error), 64'(out_error));
        end
      end
    end
  end

endmodule

// ----- verif/rns_mixed_radix_conversion_unit_tb.sv -----
`timescale 1ns / 1ps
module rns_mixed_radix_conversion_unit_tb import mrc_pkg::*;;

  localparam logic [CFG_IW-1:0] REG_MODULUS_0 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_UNMAPPED  = 3'd7;
  localparam int DRAIN_CYCLES = 40;   // a bit over the pipeline depth
  localparam int HOLD_CYCLES  = 300;  // long enough to back up the whole pipeline

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MW-1:0]     in_residue_0 = '0, in_residue_1 = '0, in_residue_2 = '0, in_residue_3 = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VALW-1:0]   out_value;
  logic [MW-1:0]     out_digit_0, out_digit_1, out_digit_2, out_digit_3;
  logic              out_error;
  int                mismatches, pending;

  // Stimulus-side copy of the moduli, used only to aim residues in range.
  logic [SLOTS-1:0][MW-1:0] moduli = MOD_RESET;
  int  burst_left = 0;
  bit  hold_req = 0, hold_ack = 0;

  always #10 clk = ~clk;

  rns_mixed_radix_conversion_unit u_top (.*);

  rns_mixed_radix_conversion_unit_checker u_checker (.*);

  // Receiver: runs of full throughput and runs of random stalls; a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int run, pct;
    @(posedge rst_n);
    forever begin
      if (hold_req != hold_ack) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack = hold_req;
      end
      run = $urandom_range(4, 40);
      pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(15, 85);
      repeat (run) begin
        out_ready <= ($urandom_range(1, 100) <= pct);
        @(posedge clk);
      end
    end
  end

  // Hold until nothing is in flight, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_moduli(input logic [SLOTS-1:0][MW-1:0] m);
    drain();
    for (int i = 0; i < SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_MODULUS_0 + CFG_IW'(i);
      cfg_wdata <= m[i];
      @(posedge clk);
    end
    // a write past the last modulus must leave the base alone
    cfg_index <= REG_UNMAPPED;
    cfg_wdata <= CFG_DW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    moduli = m;
  endtask

  // Offer one beat and hold it until taken; gap between bursts afterwards.
  task automatic send(input logic [SLOTS-1:0][MW-1:0] r);
    in_valid     <= 1'b1;
    in_residue_0 <= r[0];
    in_residue_1 <= r[1];
    in_residue_2 <= r[2];
    in_residue_3 <= r[3];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [SLOTS-1:0][MW-1:0] pick_residues();
    logic [SLOTS-1:0][MW-1:0] r;
    for (int i = 0; i < SLOTS; i++)
      if ($urandom_range(0, 19) == 0 || moduli[i] < 2) r[i] = MW'($urandom);
      else r[i] = MW'($urandom_range(0, moduli[i] - 1));
    return r;
  endfunction

  task automatic directed_edges();
    logic [SLOTS-1:0][MW-1:0] top;
    for (int i = 0; i < SLOTS; i++) top[i] = (moduli[i] < 1) ? '0 : moduli[i] - MW'(1);
    send('0);
    send(top);
    send({SLOTS{16'hFFFF}});
    // each residue in turn lands exactly on its modulus
    for (int i = 0; i < SLOTS; i++) begin
      logic [SLOTS-1:0][MW-1:0] r;
      r = top;
      r[i] = moduli[i];
      send(r);
    end
  endtask

  logic [SLOTS-1:0][MW-1:0] bases[8] = '{
    {16'd65479, 16'd65497, 16'd65519, 16'd65521},
    {16'd7,     16'd5,     16'd3,     16'd2},
    {16'd65521, 16'd65533, 16'd65534, 16'd65535},
    {16'd251,   16'd253,   16'd255,   16'd256},
    {16'd29,    16'd23,    16'd19,    16'd17},
    {16'd7,     16'd5,     16'd6,     16'd4},
    {16'd7,     16'd5,     16'd3,     16'd1},
    {16'd3,     16'd0,     16'd5,     16'd7}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset base, then every fixed base including the broken ones
    directed_edges();
    for (int b = 1; b < 8; b++) begin
      load_moduli(bases[b]);
      directed_edges();
    end

    // random: well-formed bases mostly, broken and random ones now and then
    for (int ph = 0; ph < 9; ph++) begin
      logic [SLOTS-1:0][MW-1:0] m;
      if (ph == 8) for (int i = 0; i < SLOTS; i++) m[i] = MW'($urandom);
      else m = bases[(ph < 5) ? ph : ph - 5 + (ph == 7 ? 3 : 0)];
      load_moduli(m);
      if (ph == 2) hold_req = ~hold_req;
      for (int n = 0; n < 120; n++) begin
        if (ph == 3 && n == 60) drain();
        send(pick_residues());
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
